@@ sv/sprite_blitter_2x_defines.svh @@
// Assertion macros for the sprite blitter.
// Included by the top level; no other dependencies.
`ifndef SPRITE_BLITTER_2X_DEFINES_SVH
`define SPRITE_BLITTER_2X_DEFINES_SVH

`ifndef ASSERT_OFF
// Implication-style property checked on every rising edge outside reset.
`define SBX_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");
// Expression that must never be true outside reset.
`define SBX_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
		else $error("forbidden condition seen");
`else
`define SBX_ASSERT(label, clk, rst_n, prop)
`define SBX_NEVER(label, clk, rst_n, expr)
`endif

`endif

@@ sv/sbx_pkg.sv @@
// Shared types and register codes for the sprite blitter.
// No dependencies; used by every module of the block.
package sbx_pkg;

	localparam int ROW_W = 32;
	localparam int ADDR_W = 19;

	// register indexes, byte address 4*index
	localparam logic [2:0] REG_ORIGIN_X      = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y      = 3'd1;
	localparam logic [2:0] REG_SPRITE_WIDTH  = 3'd2;
	localparam logic [2:0] REG_SPRITE_HEIGHT = 3'd3;
	localparam logic [2:0] REG_SCALE_2X      = 3'd4;
	localparam logic [2:0] REG_DRAW_COLOR    = 3'd5;
	localparam logic [2:0] REG_ERASE_MODE    = 3'd6;
	localparam logic [2:0] REG_TARGET_FRAME  = 3'd7;

	typedef struct packed {
		logic [9:0]  origin_x;
		logic [8:0]  origin_y;
		logic [5:0]  sprite_width;
		logic [5:0]  sprite_height;
		logic        scale_2x;
		logic [23:0] draw_color;
		logic        erase_mode;
		logic        target_frame;
	} cfg_t;

	// one classified row, handed from the front to the back
	typedef struct packed {
		logic [ROW_W-1:0]  bits;      // leftmost used pixel at the top bit
		logic [5:0]        cols;      // columns to emit, 1..32
		logic              last_row;
		logic [ADDR_W-1:0] base;      // y * screen width, truncated
		logic              off_y;
	} row_job_t;

endpackage

@@ sv/sbx_front.sv @@
// Front end: accepts row words, tracks the row counter and classifies each row.
// Depends on sbx_pkg.
module sbx_front #(
	parameter int SCREEN_WIDTH = 640,
	parameter int SCREEN_HEIGHT = 480,
	parameter int MAX_SPRITE_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sbx_pkg::cfg_t            cfg,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [sbx_pkg::ROW_W-1:0] in_bits,
	input  logic                     q_full,
	output logic                     q_push,
	output sbx_pkg::row_job_t        q_job
);

	localparam int WCAP = (MAX_SPRITE_WIDTH < 32) ? MAX_SPRITE_WIDTH : 32;

	logic [4:0] row_q;
	logic [5:0] w_eff;
	logic [5:0] h_eff;
	logic       last_row;
	logic [5:0] row_off;
	logic [9:0] y;
	logic [9:0] y_end;
	logic       accept;

	always_comb begin
		w_eff = (cfg.sprite_width > 6'(WCAP)) ? 6'(WCAP) : cfg.sprite_width;
		if (cfg.sprite_height == 6'd0) begin
			h_eff = 6'd1;
		end else if (cfg.sprite_height > 6'd32) begin
			h_eff = 6'd32;
		end else begin
			h_eff = cfg.sprite_height;
		end
		last_row = ({1'b0, row_q} + 6'd1) >= h_eff;
		row_off = cfg.scale_2x ? {row_q, 1'b0} : {1'b0, row_q};
		y = {1'b0, cfg.origin_y} + {4'b0, row_off};
		y_end = y + {9'b0, cfg.scale_2x};
	end

	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;
	// a row of width zero is consumed but queues nothing
	assign q_push = accept && (w_eff != 6'd0);

	assign q_job.bits = in_bits << (6'd32 - w_eff);
	assign q_job.cols = w_eff;
	assign q_job.last_row = last_row;
	assign q_job.base = {9'b0, y} * sbx_pkg::ADDR_W'(SCREEN_WIDTH);
	assign q_job.off_y = {3'b0, y_end} >= 13'(SCREEN_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= 5'd0;
		end else if (accept) begin
			row_q <= last_row ? 5'd0 : row_q + 5'd1;
		end
	end

endmodule

@@ sv/sbx_queue.sv @@
// Two-entry queue of classified rows between the front and the back.
// Depends on sbx_pkg.
module sbx_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sbx_pkg::row_job_t push_job,
	output logic              full,
	input  logic              pop,
	output logic              valid,
	output sbx_pkg::row_job_t head
);

	sbx_pkg::row_job_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full = count_q == 2'd2;
	assign valid = count_q != 2'd0;
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ sv/sbx_back.sv @@
// Back end: walks the columns of one queued row and drives the output register.
// Depends on sbx_pkg.
module sbx_back #(
	parameter int SCREEN_WIDTH = 640
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sbx_pkg::cfg_t              cfg,
	input  logic                       q_valid,
	input  sbx_pkg::row_job_t          q_head,
	output logic                       q_pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [sbx_pkg::ADDR_W-1:0] out_address,
	output logic [23:0]                out_color,
	output logic                       out_block,
	output logic                       out_background,
	output logic                       out_frame,
	output logic                       out_off_screen,
	output logic                       out_last_row_col,
	output logic                       out_last_sprite
);

	logic                       busy_q;
	logic [sbx_pkg::ROW_W-1:0]  shift_q;
	logic [5:0]                 left_q;
	logic [10:0]                x_q;
	logic [sbx_pkg::ADDR_W-1:0] base_q;
	logic                       off_y_q;
	logic                       last_row_q;

	logic        advance;
	logic        last_col;
	logic        bg;
	logic [10:0] x_end;

	assign advance = busy_q && (!out_valid || out_ready);
	assign last_col = left_q == 6'd1;
	assign bg = !(shift_q[sbx_pkg::ROW_W-1] && !cfg.erase_mode);
	assign x_end = x_q + {10'b0, cfg.scale_2x};
	// load the next row on the cycle the current one emits its last column
	assign q_pop = q_valid && (!busy_q || (advance && last_col));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (advance) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (q_pop) begin
				busy_q <= 1'b1;
			end else if (advance && last_col) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			shift_q <= q_head.bits;
			left_q <= q_head.cols;
			x_q <= {1'b0, cfg.origin_x};
			base_q <= q_head.base;
			off_y_q <= q_head.off_y;
			last_row_q <= q_head.last_row;
		end else if (advance) begin
			shift_q <= shift_q << 1;
			left_q <= left_q - 6'd1;
			x_q <= x_q + (cfg.scale_2x ? 11'd2 : 11'd1);
		end
		if (advance) begin
			out_address <= base_q + {8'b0, x_q};
			out_color <= bg ? 24'd0 : cfg.draw_color;
			out_block <= cfg.scale_2x;
			out_background <= bg;
			out_frame <= cfg.target_frame;
			out_off_screen <= off_y_q || ({2'b0, x_end} >= 13'(SCREEN_WIDTH));
			out_last_row_col <= last_col;
			out_last_sprite <= last_col && last_row_q;
		end
	end

endmodule

@@ sv/sprite_blitter_2x.sv @@
// Sprite blitter, 1 bit per pixel, optional 2x2 scale. First result is registered in the
// output register after its row word passes the queue and loads into the free column walker.
// Throughput: one result per cycle while m_axis_tready does not stall the output, set by the
// single column walker in the back end; a zero-width row is consumed with no result.
// Reset clears the row counter, queue and output valid and loads register defaults;
// there is no clearing pass.
`include "sprite_blitter_2x_defines.svh"

module sprite_blitter_2x #(
	parameter int SCREEN_WIDTH = 640,
	parameter int SCREEN_HEIGHT = 480,
	parameter int MAX_SPRITE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] row_bits
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [18:0] pixel_address, [42:19] pixel_color, rest 0
	output logic [4:0]  m_axis_tuser,   // [0] block_2x2, [1] use_background,
	                                    // [2] frame_select, [3] off_screen, [4] last_in_sprite
	output logic        m_axis_tlast    // last_in_row
);

	sbx_pkg::cfg_t     cfg_q;
	sbx_pkg::row_job_t push_job;
	sbx_pkg::row_job_t head_job;
	logic       q_full;
	logic       q_push;
	logic       q_pop;
	logic       q_valid;
	logic       cfg_write;
	logic [2:0] reg_idx;
	logic [18:0] out_address;
	logic [23:0] out_color;
	logic       out_block;
	logic       out_background;
	logic       out_frame;
	logic       out_off_screen;
	logic       out_last_sprite;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x <= 10'd0;
			cfg_q.origin_y <= 9'd0;
			cfg_q.sprite_width <= 6'd12;
			cfg_q.sprite_height <= 6'd8;
			cfg_q.scale_2x <= 1'b1;
			cfg_q.draw_color <= 24'hFFFFFF;
			cfg_q.erase_mode <= 1'b0;
			cfg_q.target_frame <= 1'b0;
		end else if (cfg_write) begin
			unique case (reg_idx)
				sbx_pkg::REG_ORIGIN_X:      cfg_q.origin_x <= pwdata[9:0];
				sbx_pkg::REG_ORIGIN_Y:      cfg_q.origin_y <= pwdata[8:0];
				sbx_pkg::REG_SPRITE_WIDTH:  cfg_q.sprite_width <= pwdata[5:0];
				sbx_pkg::REG_SPRITE_HEIGHT: cfg_q.sprite_height <= pwdata[5:0];
				sbx_pkg::REG_SCALE_2X:      cfg_q.scale_2x <= pwdata[0];
				sbx_pkg::REG_DRAW_COLOR:    cfg_q.draw_color <= pwdata[23:0];
				sbx_pkg::REG_ERASE_MODE:    cfg_q.erase_mode <= pwdata[0];
				sbx_pkg::REG_TARGET_FRAME:  cfg_q.target_frame <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			sbx_pkg::REG_ORIGIN_X:      prdata = {22'b0, cfg_q.origin_x};
			sbx_pkg::REG_ORIGIN_Y:      prdata = {23'b0, cfg_q.origin_y};
			sbx_pkg::REG_SPRITE_WIDTH:  prdata = {26'b0, cfg_q.sprite_width};
			sbx_pkg::REG_SPRITE_HEIGHT: prdata = {26'b0, cfg_q.sprite_height};
			sbx_pkg::REG_SCALE_2X:      prdata = {31'b0, cfg_q.scale_2x};
			sbx_pkg::REG_DRAW_COLOR:    prdata = {8'b0, cfg_q.draw_color};
			sbx_pkg::REG_ERASE_MODE:    prdata = {31'b0, cfg_q.erase_mode};
			sbx_pkg::REG_TARGET_FRAME:  prdata = {31'b0, cfg_q.target_frame};
			default:                    prdata = 32'd0;
		endcase
	end

	sbx_front #(
		.SCREEN_WIDTH(SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT),
		.MAX_SPRITE_WIDTH(MAX_SPRITE_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_bits(s_axis_tdata),
		.q_full(q_full),
		.q_push(q_push),
		.q_job(push_job)
	);

	sbx_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_job(push_job),
		.full(q_full),
		.pop(q_pop),
		.valid(q_valid),
		.head(head_job)
	);

	sbx_back #(
		.SCREEN_WIDTH(SCREEN_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_valid(q_valid),
		.q_head(head_job),
		.q_pop(q_pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_address(out_address),
		.out_color(out_color),
		.out_block(out_block),
		.out_background(out_background),
		.out_frame(out_frame),
		.out_off_screen(out_off_screen),
		.out_last_row_col(m_axis_tlast),
		.out_last_sprite(out_last_sprite)
	);

	assign m_axis_tdata = {5'b0, out_color, out_address};
	assign m_axis_tuser = {out_last_sprite, out_off_screen, out_frame, out_background, out_block};

	// background copies never carry a color
	`SBX_NEVER(a_bg_no_color, clk, arst_n, m_axis_tvalid && out_background && (out_color != 24'd0))
	// end of sprite only on the last column of a row
	`SBX_ASSERT(a_sprite_end_row, clk, arst_n, m_axis_tvalid && m_axis_tuser[4] |-> m_axis_tlast)
	// the back never pops an empty queue
	`SBX_NEVER(a_pop_empty, clk, arst_n, q_pop && !q_valid)

endmodule
